/* rtl/ccinterp_pkg.sv */
// ----------------------------------------------------------------------------
// ccinterp_pkg
// Shared constants and types for the cubic color interpolator.
// ----------------------------------------------------------------------------
package ccinterp_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int CHAN_COUNT  = 3;
    localparam int CHAN_BITS   = 8;
    localparam int COLOR_BITS  = CHAN_BITS * CHAN_COUNT;

    // lane register stages plus the merge register
    localparam int LANE_STAGES = 4;
    localparam int PIPE_STAGES = LANE_STAGES + 1;

    // 6 * value saturates at 6 * 256
    localparam int SAT_LIMIT    = 6 * (2 ** CHAN_BITS);
    localparam int DIV_IN_BITS  = $clog2(SAT_LIMIT);
    localparam int RECIP_SHIFT  = DIV_IN_BITS + 7;
    localparam int RECIP6       = (2 ** RECIP_SHIFT + 5) / 6;
    localparam int RECIP_BITS   = $clog2(RECIP6 + 1);

    typedef struct packed {
        logic [LANE_STAGES-1:0] lane_load;
        logic                   merge_load;
    } pipe_ctrl_t;

endpackage

/* rtl/cubic_color_interpolator_unit.sv */
// ----------------------------------------------------------------------------
// cubic_color_interpolator_unit
// Cubic Lagrange interpolation of packed colors, one lane per channel,
// merged into one packed result register.
// ----------------------------------------------------------------------------
// channel   | direction | ports
// s_ (item) | in        | s_valid, s_ready, s_fraction, s_color_at_*
// m_ (res)  | out       | m_valid, m_ready, m_blended_color
//
// One transfer in and one out per cycle when the sink keeps up.
// The pipeline is four lane stages and the merge register that
// drives m_blended_color.
// Synchronous active-low reset clears the stage valid bits only.
// Each stage holds while its successor is full and stalled; empty stages
// keep filling, so s_ready drops only once all five stages are occupied.
// ----------------------------------------------------------------------------
module cubic_color_interpolator_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [ccinterp_pkg::FRAC_BITS-1:0]   s_fraction,
    input  logic [ccinterp_pkg::COLOR_BITS-1:0]  s_color_at_minus_one,
    input  logic [ccinterp_pkg::COLOR_BITS-1:0]  s_color_at_zero,
    input  logic [ccinterp_pkg::COLOR_BITS-1:0]  s_color_at_one,
    input  logic [ccinterp_pkg::COLOR_BITS-1:0]  s_color_at_two,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [ccinterp_pkg::COLOR_BITS-1:0]  m_blended_color
);
    import ccinterp_pkg::*;

    pipe_ctrl_t              pipe_ctrl;
    logic [COLOR_BITS-1:0]   blended_next;
    logic [COLOR_BITS-1:0]   blended_reg;

    ccinterp_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .pipe_ctrl (pipe_ctrl)
    );

    for (genvar k = 0; k < CHAN_COUNT; k++) begin : g_lane
        ccinterp_lane u_lane (
            .aclk       (aclk),
            .load       (pipe_ctrl.lane_load),
            .frac       (s_fraction),
            .p0         (s_color_at_minus_one[k*CHAN_BITS +: CHAN_BITS]),
            .p1         (s_color_at_zero[k*CHAN_BITS +: CHAN_BITS]),
            .p2         (s_color_at_one[k*CHAN_BITS +: CHAN_BITS]),
            .p3         (s_color_at_two[k*CHAN_BITS +: CHAN_BITS]),
            .chan_value (blended_next[k*CHAN_BITS +: CHAN_BITS])
        );
    end

    always_ff @(posedge aclk) begin
        if (pipe_ctrl.merge_load) begin
            blended_reg <= blended_next;
        end
    end

    assign m_blended_color = blended_reg;

endmodule

/* rtl/ccinterp_ctrl.sv */
// ----------------------------------------------------------------------------
// ccinterp_ctrl
// Valid/ready control for the interpolator pipeline; stages fill bubbles.
// ----------------------------------------------------------------------------
module ccinterp_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  logic                     m_ready,
    output ccinterp_pkg::pipe_ctrl_t pipe_ctrl
);
    import ccinterp_pkg::*;

    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES-1:0] valid_next;
    logic [PIPE_STAGES-1:0] valid_in;
    logic [PIPE_STAGES:0]   rdy;

    assign valid_in = {valid_reg[PIPE_STAGES-2:0], s_valid};

    always_comb begin
        rdy[PIPE_STAGES] = m_ready;
        for (int i = PIPE_STAGES - 1; i >= 0; i--) begin
            rdy[i] = ~valid_reg[i] | rdy[i+1];
        end
        for (int i = 0; i < PIPE_STAGES; i++) begin
            valid_next[i] = rdy[i] ? valid_in[i] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready              = rdy[0];
    assign m_valid              = valid_reg[PIPE_STAGES-1];
    assign pipe_ctrl.lane_load  = rdy[LANE_STAGES-1:0];
    assign pipe_ctrl.merge_load = rdy[PIPE_STAGES-1];

endmodule

/* rtl/ccinterp_lane.sv */
// ----------------------------------------------------------------------------
// ccinterp_lane
// One color channel: cubic Lagrange evaluation in Horner form, four stages,
// then floor divide by six and saturation to the channel range.
// ----------------------------------------------------------------------------
module ccinterp_lane (
    input  logic                                   aclk,
    input  logic [ccinterp_pkg::LANE_STAGES-1:0]   load,
    input  logic [ccinterp_pkg::FRAC_BITS-1:0]     frac,
    input  logic [ccinterp_pkg::CHAN_BITS-1:0]     p0,
    input  logic [ccinterp_pkg::CHAN_BITS-1:0]     p1,
    input  logic [ccinterp_pkg::CHAN_BITS-1:0]     p2,
    input  logic [ccinterp_pkg::CHAN_BITS-1:0]     p3,
    output logic [ccinterp_pkg::CHAN_BITS-1:0]     chan_value
);
    import ccinterp_pkg::*;

    localparam int CW  = CHAN_BITS + 4;
    localparam int T1W = FRAC_BITS + CHAN_BITS + 5;
    localparam int T2W = 2 * FRAC_BITS + CHAN_BITS + 6;
    localparam int HW  = T2W - FRAC_BITS;
    localparam int HFW = HW + FRAC_BITS + 1;
    localparam int LFW = 2 * FRAC_BITS;
    localparam int YW  = HFW + 1;
    localparam int QW  = YW - 2 * FRAC_BITS;
    localparam int SW  = QW + 1;
    localparam int PW  = DIV_IN_BITS + RECIP_BITS;

    // stage 1: coefficients and A*f + B*2^F
    logic signed [CW-1:0]  e0, e1, e2, e3;
    logic signed [CW-1:0]  coef_a, coef_b, coef_c;
    logic signed [FRAC_BITS:0] f0_s;
    logic signed [T1W-1:0] t1;

    logic signed [T1W-1:0]     t1_reg;
    logic signed [CW-1:0]      c1_reg;
    logic [FRAC_BITS-1:0]      f1_reg;
    logic [CHAN_BITS-1:0]      p1_1_reg;

    // stage 2: t1*f + C*2^2F
    logic signed [FRAC_BITS:0] f1_s;
    logic signed [T2W-1:0]     t2;

    logic signed [T2W-1:0]     t2_reg;
    logic [FRAC_BITS-1:0]      f2_reg;
    logic [CHAN_BITS-1:0]      p1_2_reg;

    // stage 3: split t2 and multiply both halves by f
    logic signed [FRAC_BITS:0] f2_s;
    logic signed [HW-1:0]      t2_hi;
    logic [LFW-1:0]            lf;
    logic signed [HFW-1:0]     hf;

    logic signed [HFW-1:0]     hf_reg;
    logic [FRAC_BITS-1:0]      lfh_reg;
    logic [CHAN_BITS-1:0]      p1_3_reg;

    // stage 4: floor(P / 2^3F) + 6*p1
    logic signed [YW-1:0]      y;
    logic signed [QW-1:0]      q;
    logic signed [SW-1:0]      p1_ext;
    logic signed [SW-1:0]      s;

    logic signed [SW-1:0]      s_reg;

    // output: divide by six, saturate
    logic [PW-1:0]             prod;

    always_comb begin
        e0     = signed'(CW'(p0));
        e1     = signed'(CW'(p1));
        e2     = signed'(CW'(p2));
        e3     = signed'(CW'(p3));
        coef_a = -e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2 + e3;
        coef_b = (e0 <<< 1) + e0 - (e1 <<< 2) - (e1 <<< 1) + (e2 <<< 1) + e2;
        coef_c = -(e0 <<< 1) - (e1 <<< 1) - e1 + (e2 <<< 2) + (e2 <<< 1) - e3;
        f0_s   = signed'({1'b0, frac});
        t1     = T1W'(coef_a) * T1W'(f0_s) + (T1W'(coef_b) <<< FRAC_BITS);
    end

    always_comb begin
        f1_s = signed'({1'b0, f1_reg});
        t2   = T2W'(t1_reg) * T2W'(f1_s) + (T2W'(c1_reg) <<< (2 * FRAC_BITS));
    end

    always_comb begin
        f2_s  = signed'({1'b0, f2_reg});
        t2_hi = signed'(t2_reg[T2W-1:FRAC_BITS]);
        hf    = HFW'(t2_hi) * HFW'(f2_s);
        lf    = LFW'(t2_reg[FRAC_BITS-1:0]) * LFW'(f2_reg);
    end

    always_comb begin
        y      = YW'(hf_reg) + YW'(signed'({1'b0, lfh_reg}));
        q      = signed'(y[YW-1:2*FRAC_BITS]);
        p1_ext = signed'(SW'(p1_3_reg));
        s      = SW'(q) + (p1_ext <<< 2) + (p1_ext <<< 1);
    end

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            t1_reg   <= t1;
            c1_reg   <= coef_c;
            f1_reg   <= frac;
            p1_1_reg <= p1;
        end
        if (load[1]) begin
            t2_reg   <= t2;
            f2_reg   <= f1_reg;
            p1_2_reg <= p1_1_reg;
        end
        if (load[2]) begin
            hf_reg   <= hf;
            lfh_reg  <= lf[LFW-1:FRAC_BITS];
            p1_3_reg <= p1_2_reg;
        end
        if (load[3]) begin
            s_reg    <= s;
        end
    end

    always_comb begin
        prod = PW'(s_reg[DIV_IN_BITS-1:0]) * PW'(RECIP6);
        if (s_reg[SW-1]) begin
            chan_value = '0;
        end else if (s_reg > signed'(SW'(SAT_LIMIT - 1))) begin
            chan_value = '1;
        end else begin
            chan_value = prod[RECIP_SHIFT+CHAN_BITS-1:RECIP_SHIFT];
        end
    end

endmodule
